// ===== rtl/core/mma_pkg.sv =====
package mma_pkg;

    localparam int RACKS   = 16;
    localparam int WINDOW  = 4;
    localparam int RACK_W  = $clog2(RACKS);
    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int ADDR_W  = RACK_W + SLOT_W;
    localparam int DEPTH   = RACKS * WINDOW;
    localparam int CNT_W   = 5;
    localparam int SMP_W   = 12;
    localparam int SUM_W   = 14;
    localparam int MAG_W   = 14;
    localparam int DIV_W   = 3;
    localparam int FRAC_W  = 8;
    localparam int AVG_W   = 20;
    localparam int WIDE_W  = MAG_W + FRAC_W;
    localparam int RCP_W   = 15;
    localparam int PROD_W  = MAG_W + RCP_W;
    localparam int QUO_W   = PROD_W - 16;

    // 2^16 / 3 rounded up; exact floor for values below 2^14
    localparam logic [RCP_W-1:0] RECIP3 = RCP_W'(21846);

    localparam logic [CNT_W-1:0] RACK_COUNT_RESET = CNT_W'(16);

    // divisor codes
    localparam logic [DIV_W-1:0] DIV_ONE   = DIV_W'(1);
    localparam logic [DIV_W-1:0] DIV_TWO   = DIV_W'(2);
    localparam logic [DIV_W-1:0] DIV_THREE = DIV_W'(3);
    localparam logic [DIV_W-1:0] DIV_FOUR  = DIV_W'(4);

    typedef struct packed {
        logic [RACK_W-1:0]       rack;
        logic [SLOT_W-1:0]       slot;
        logic [DIV_W-1:0]        div;
        logic signed [SMP_W-1:0] sample;
    } t_item;

    typedef struct packed {
        logic                    vld;
        logic [RACK_W-1:0]       rack;
        logic [DIV_W-1:0]        div;
        logic signed [SUM_W-1:0] sum;
    } t_sum_item;

    // fraction bits of (rem * 256) / 3 for a remainder of 0..2
    function automatic logic [FRAC_W-1:0] frac_third(input logic [1:0] rem);
        logic [FRAC_W-1:0] f;
        case (rem)
            2'd1:    f = FRAC_W'(85);
            2'd2:    f = FRAC_W'(170);
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/core/mma_store.sv =====
module mma_store
    import mma_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  logic      i_take,
    input  t_item     i_item,
    output t_sum_item o_sum
);

    logic signed [SMP_W-1:0] r_smp_mem [DEPTH];
    logic signed [SUM_W-1:0] r_sum_mem [RACKS];
    logic [DEPTH-1:0]        r_smp_ok;
    logic [RACKS-1:0]        r_sum_ok;

    logic                    r_s1_vld;
    t_item                   r_s1_item;
    logic signed [SMP_W-1:0] r_smp_rd;
    logic signed [SUM_W-1:0] r_sum_rd;
    logic                    r_smp_rd_ok;
    logic                    r_sum_rd_ok;
    logic                    r_fwd_smp;
    logic                    r_fwd_sum;
    logic signed [SMP_W-1:0] r_fwd_smp_d;
    logic signed [SUM_W-1:0] r_fwd_sum_d;

    logic [ADDR_W-1:0]       rd_addr;
    logic [ADDR_W-1:0]       s1_addr;
    logic signed [SMP_W-1:0] old_smp;
    logic signed [SUM_W-1:0] old_sum;
    logic signed [SUM_W-1:0] new_sum;
    logic                    wr_en;

    assign rd_addr = {i_item.rack, i_item.slot};
    assign s1_addr = {r_s1_item.rack, r_s1_item.slot};
    assign wr_en   = i_en && r_s1_vld;

    // pick the entry value: just-written data, stored data, or reset zero
    always_comb begin
        if (r_fwd_smp) begin
            old_smp = r_fwd_smp_d;
        end else if (r_smp_rd_ok) begin
            old_smp = r_smp_rd;
        end else begin
            old_smp = '0;
        end
        if (r_fwd_sum) begin
            old_sum = r_fwd_sum_d;
        end else if (r_sum_rd_ok) begin
            old_sum = r_sum_rd;
        end else begin
            old_sum = '0;
        end
        new_sum = old_sum
                - {{(SUM_W-SMP_W){old_smp[SMP_W-1]}}, old_smp}
                + {{(SUM_W-SMP_W){r_s1_item.sample[SMP_W-1]}}, r_s1_item.sample};
    end

    // memory write and registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_smp_mem[s1_addr]        <= r_s1_item.sample;
            r_sum_mem[r_s1_item.rack] <= new_sum;
        end
        if (i_en) begin
            r_smp_rd <= r_smp_mem[rd_addr];
            r_sum_rd <= r_sum_mem[i_item.rack];
        end
    end

    // entry valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp_ok <= '0;
            r_sum_ok <= '0;
        end else if (wr_en) begin
            r_smp_ok[s1_addr]        <= 1'b1;
            r_sum_ok[r_s1_item.rack] <= 1'b1;
        end
    end

    // advance read stage, capture forwarding when the write collides
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_en) begin
            r_s1_vld <= i_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_item   <= i_item;
            r_smp_rd_ok <= r_smp_ok[rd_addr];
            r_sum_rd_ok <= r_sum_ok[i_item.rack];
            r_fwd_smp   <= r_s1_vld && (s1_addr == rd_addr);
            r_fwd_sum   <= r_s1_vld && (r_s1_item.rack == i_item.rack);
            r_fwd_smp_d <= r_s1_item.sample;
            r_fwd_sum_d <= new_sum;
        end
    end

    assign o_sum.vld  = r_s1_vld;
    assign o_sum.rack = r_s1_item.rack;
    assign o_sum.div  = r_s1_item.div;
    assign o_sum.sum  = new_sum;

endmodule

// ===== rtl/core/mma_div.sv =====
module mma_div
    import mma_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  t_sum_item               i_sum,
    output logic                    o_vld,
    output logic [RACK_W-1:0]       o_rack,
    output logic signed [AVG_W-1:0] o_avg
);

    logic                    r_s2_vld;
    logic [RACK_W-1:0]       r_s2_rack;
    logic [DIV_W-1:0]        r_s2_div;
    logic                    r_s2_neg;
    logic [MAG_W-1:0]        r_s2_mag;

    logic                    r_s3_vld;
    logic [RACK_W-1:0]       r_s3_rack;
    logic [DIV_W-1:0]        r_s3_div;
    logic                    r_s3_neg;
    logic [MAG_W-1:0]        r_s3_mag;
    logic [PROD_W-1:0]       r_s3_prod;

    logic                    r_out_vld;
    logic [RACK_W-1:0]       r_out_rack;
    logic signed [AVG_W-1:0] r_out_avg;

    logic [MAG_W-1:0]        mag;
    logic [PROD_W-1:0]       prod;
    logic [QUO_W-1:0]        quo;
    logic [MAG_W-1:0]        rem;
    logic [WIDE_W-1:0]       wide_mag;
    logic [WIDE_W-1:0]       wide_sgn;

    // magnitude of the sum
    assign mag  = i_sum.sum[SUM_W-1] ? MAG_W'(-i_sum.sum) : MAG_W'(i_sum.sum);
    // reciprocal multiply for the divide by three
    assign prod = PROD_W'(r_s2_mag) * PROD_W'(RECIP3);

    // scale by 256 and divide by the window fill, then restore the sign
    always_comb begin
        quo = r_s3_prod[PROD_W-1:16];
        rem = r_s3_mag - MAG_W'({2'b00, quo} * 3);
        case (r_s3_div)
            DIV_ONE:   wide_mag = {r_s3_mag, {FRAC_W{1'b0}}};
            DIV_TWO:   wide_mag = {1'b0, r_s3_mag, {(FRAC_W-1){1'b0}}};
            DIV_THREE: wide_mag = {1'b0, quo, frac_third(rem[1:0])};
            DIV_FOUR:  wide_mag = {2'b00, r_s3_mag, {(FRAC_W-2){1'b0}}};
            default:   wide_mag = '0;
        endcase
        wide_sgn = r_s3_neg ? (~wide_mag + WIDE_W'(1)) : wide_mag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_s2_vld  <= i_sum.vld;
            r_s3_vld  <= r_s2_vld;
            r_out_vld <= r_s3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s2_rack  <= i_sum.rack;
            r_s2_div   <= i_sum.div;
            r_s2_neg   <= i_sum.sum[SUM_W-1];
            r_s2_mag   <= mag;
            r_s3_rack  <= r_s2_rack;
            r_s3_div   <= r_s2_div;
            r_s3_neg   <= r_s2_neg;
            r_s3_mag   <= r_s2_mag;
            r_s3_prod  <= prod;
            r_out_rack <= r_s3_rack;
            r_out_avg  <= wide_sgn[AVG_W-1:0];
        end
    end

    assign o_vld  = r_out_vld;
    assign o_rack = r_out_rack;
    assign o_avg  = r_out_avg;

endmodule

// ===== rtl/core/multichannel_moving_average.sv =====
// Per-rack moving average over the last four frames. One sample is taken per
// cycle unless the output stalls: each transfer reads the rack's running sum
// and the ring slot it replaces from on-chip memories, writes both back from
// the read stage (with forwarding when back-to-back samples hit the same
// rack), and the mean then passes a reciprocal-multiply divider. Results
// appear in sample order. The whole pipeline moves as one, so a stalled
// result also stalls the input. Frame count and ring position advance when
// the sample for rack (rack_count - 1) is taken; rack_count of zero acts as
// one and values above sixteen act as sixteen. The stores read as zero after
// reset without any clearing pass.
module multichannel_moving_average
    import mma_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CNT_W-1:0]        i_cfg_wdata,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [RACK_W-1:0]       i_rack_index,
    input  logic signed [SMP_W-1:0] i_temperature,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [RACK_W-1:0]       o_rack_id,
    output logic signed [AVG_W-1:0] o_average
);

    logic [CNT_W-1:0]  r_rack_count;
    logic [DIV_W-1:0]  r_frames;
    logic [SLOT_W-1:0] r_slot;
    logic [DIV_W-1:0]  n_frames;
    logic [SLOT_W-1:0] n_slot;

    logic              en;
    logic              take;
    logic [CNT_W-1:0]  eff_racks;
    logic              frame_end;
    t_item             item;
    t_sum_item         sum_item;

    assign en         = !o_out_valid || !i_out_stall;
    assign o_in_stall = !en;
    assign take       = i_in_valid && en;

    // clamp the rack count to 1..RACKS
    always_comb begin
        if (r_rack_count == '0) begin
            eff_racks = CNT_W'(1);
        end else if (r_rack_count > CNT_W'(RACKS)) begin
            eff_racks = CNT_W'(RACKS);
        end else begin
            eff_racks = r_rack_count;
        end
    end

    assign frame_end = ({1'b0, i_rack_index} == eff_racks - CNT_W'(1));

    // advance frame count and ring slot at the end of a frame
    always_comb begin
        n_frames = r_frames;
        n_slot   = r_slot;
        if (take && frame_end) begin
            n_slot = r_slot + SLOT_W'(1);
            if (r_frames < DIV_W'(WINDOW)) begin
                n_frames = r_frames + DIV_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rack_count <= RACK_COUNT_RESET;
            r_frames     <= '0;
            r_slot       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_rack_count <= i_cfg_wdata;
            end
            r_frames <= n_frames;
            r_slot   <= n_slot;
        end
    end

    // divisor is the window fill including this sample
    assign item.rack   = i_rack_index;
    assign item.slot   = r_slot;
    assign item.div    = (r_frames >= DIV_W'(WINDOW)) ? DIV_W'(WINDOW)
                                                      : r_frames + DIV_W'(1);
    assign item.sample = i_temperature;

    mma_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_take  (take),
        .i_item  (item),
        .o_sum   (sum_item)
    );

    mma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_sum   (sum_item),
        .o_vld   (o_out_valid),
        .o_rack  (o_rack_id),
        .o_avg   (o_average)
    );

endmodule

// ===== bench/multichannel_moving_average_tb.sv =====
module multichannel_moving_average_tb;
    import mma_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 190;
    localparam int PRINT_LIMIT  = 100;

    typedef struct packed {
        logic [RACK_W-1:0]       rack;
        logic signed [SMP_W-1:0] temp;
    } sample_t;

    typedef struct packed {
        logic [RACK_W-1:0]       rack;
        logic signed [AVG_W-1:0] avg;
    } mean_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CNT_W-1:0]        i_cfg_wdata = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_stall;
    logic [RACK_W-1:0]       i_rack_index = '0;
    logic signed [SMP_W-1:0] i_temperature = '0;
    logic                    o_out_valid;
    logic                    i_out_stall = 1'b0;
    logic [RACK_W-1:0]       o_rack_id;
    logic signed [AVG_W-1:0] o_average;

    sample_t pending_samples[$];
    mean_t   expected_means[$];

    // shadow of the per-rack rings, sums and the global frame state
    logic signed [SMP_W-1:0] ring_model [RACKS][WINDOW];
    int                      window_total [RACKS];
    int                      frames_done;
    int                      ring_slot;
    logic [CNT_W-1:0]        racks_per_frame;

    int mismatch_count = 0;
    int samples_sent   = 0;
    int results_seen   = 0;
    int settings_used  = 0;
    int cycle_count    = 0;
    int burst_left     = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int stall_pct      = 0;

    multichannel_moving_average dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_rack_index  (i_rack_index),
        .i_temperature (i_temperature),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_rack_id     (o_rack_id),
        .o_average     (o_average)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        // keep the log short when the block is badly broken
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
    endtask

    function automatic int active_racks(input logic [CNT_W-1:0] count);
        int n;
        n = count;
        if (n == 0) n = 1;
        if (n > RACKS) n = RACKS;
        return n;
    endfunction

    // Replace the rack's current slot, update its sum and queue the mean.
    task automatic predict_mean(input sample_t s);
        int    old_val;
        int    new_val;
        int    total;
        int    divisor;
        int    mean;
        mean_t m;
        old_val = ring_model[s.rack][ring_slot];
        new_val = $signed(s.temp);
        ring_model[s.rack][ring_slot] = s.temp;
        total = window_total[s.rack] - old_val + new_val;
        window_total[s.rack] = total;
        divisor = (frames_done + 1 > WINDOW) ? WINDOW : frames_done + 1;
        mean = (total * 256) / divisor;
        m.rack = s.rack;
        m.avg  = AVG_W'(mean);
        expected_means.push_back(m);
        if (int'(s.rack) == active_racks(racks_per_frame) - 1) begin
            if (frames_done < WINDOW) frames_done++;
            ring_slot = (ring_slot + 1) % WINDOW;
        end
    endtask

    // Sender: bursts of random length separated by random gaps.
    always @(posedge i_clk) begin : drive
        sample_t nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            for (int r = 0; r < RACKS; r++) begin
                window_total[r] = 0;
                for (int w = 0; w < WINDOW; w++) ring_model[r][w] = '0;
            end
            frames_done     = 0;
            ring_slot       = 0;
            racks_per_frame = RACK_COUNT_RESET;
            burst_left      = 0;
            gap_left        = 0;
        end else begin
            if (i_cfg_we) racks_per_frame = i_cfg_wdata;
            if (i_in_valid && !o_in_stall) begin
                nxt.rack = i_rack_index;
                nxt.temp = i_temperature;
                predict_mean(nxt);
                samples_sent++;
            end
            // hold a stalled payload, otherwise load the next one or idle
            if (!i_in_valid || !o_in_stall) begin
                if (pending_samples.size() != 0 && gap_left == 0) begin
                    nxt = pending_samples.pop_front();
                    i_in_valid    <= 1'b1;
                    i_rack_index  <= nxt.rack;
                    i_temperature <= nxt.temp;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end
            end
        end
    end

    // Receiver: stall segments, each with its own stall density.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_left = $urandom_range(4, 40);
                case ($urandom_range(0, 4))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 30;
                    3:       stall_pct = 60;
                    default: stall_pct = 90;
                endcase
            end
            stall_left--;
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Compare each result transfer with the oldest expected mean.
    always @(posedge i_clk) begin : watch
        mean_t want;
        if (i_rst_n && $isunknown(o_out_valid)) begin
            report_mismatch("output valid is unknown");
        end else if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (expected_means.size() == 0) begin
                report_mismatch($sformatf("result for rack %0d with none expected",
                    o_rack_id));
            end else begin
                want = expected_means.pop_front();
                if (o_rack_id !== want.rack) begin
                    report_mismatch($sformatf("rack_id %0d, expected %0d",
                        o_rack_id, want.rack));
                end
                if (o_average !== want.avg) begin
                    report_mismatch($sformatf("rack %0d average %0d, expected %0d",
                        want.rack, o_average, want.avg));
                end
            end
        end
    end

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                cycle_count, expected_means.size());
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_sample(input int rack, input int temp);
        sample_t s;
        s.rack = RACK_W'(rack);
        s.temp = SMP_W'(temp);
        pending_samples.push_back(s);
    endtask

    function automatic int random_temp();
        case ($urandom_range(0, 9))
            0:       return -2048;
            1:       return 2047;
            2:       return $urandom_range(0, 1) ? 0 : -1;
            default: return $signed(SMP_W'($urandom()));
        endcase
    endfunction

    // Wait until every transfer is taken and every mean has come back.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_samples.size() != 0 || i_in_valid || expected_means.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_rack_count(input logic [CNT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        settings_used++;
    endtask

    // Mostly complete frames; some with dropped or repeated racks, some stray samples.
    task automatic queue_random_phase(input logic [CNT_W-1:0] count, input int n_items);
        int pushed;
        int kind;
        int racks;
        pushed = 0;
        racks = active_racks(count);
        while (pushed < n_items) begin
            kind = $urandom_range(0, 19);
            if (kind < 3) begin
                queue_sample($urandom_range(0, RACKS - 1), random_temp());
                pushed++;
            end else begin
                for (int r = 0; r < racks; r++) begin
                    if (kind < 6 && $urandom_range(0, 7) == 0) continue;
                    queue_sample(r, random_temp());
                    pushed++;
                    if (kind < 6 && $urandom_range(0, 7) == 0) begin
                        queue_sample(r, random_temp());
                        pushed++;
                    end
                end
            end
        end
    endtask

    initial begin : stimulus
        logic [CNT_W-1:0] settings [6];
        logic [CNT_W-1:0] cfg;
        settings = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd3};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset rack count: rack 15 closes the first frame
        queue_sample(15, 2047);
        queue_sample(0, -2048);
        wait_idle();

        // two racks per frame: warm-up through a full window at the extremes
        write_rack_count(5'd2);
        queue_sample(0, -2048);
        queue_sample(1, 2047);
        for (int f = 0; f < 4; f++) begin
            queue_sample(0, -2048);
            queue_sample(1, 2047);
        end
        queue_sample(0, -1);
        queue_sample(1, 0);
        // racks past the count: processed, never close a frame
        queue_sample(15, 1234);
        queue_sample(9, -5);
        // rack 0 skipped, then rack 0 repeated
        queue_sample(1, 7);
        queue_sample(0, 1);
        queue_sample(0, -3);
        queue_sample(1, -1);
        queue_sample(0, 0);
        queue_sample(1, -7);
        wait_idle();

        // random phases over fixed and random rack counts
        for (int p = 0; p < 10; p++) begin
            cfg = (p < 6) ? settings[p] : CNT_W'($urandom_range(0, 31));
            write_rack_count(cfg);
            queue_random_phase(cfg, PHASE_ITEMS);
            wait_idle();
        end

        repeat (10) @(posedge i_clk);
        $display("sent %0d samples, checked %0d means over %0d rack-count writes",
            samples_sent, results_seen, settings_used);
        $display("%0d mismatches, %0d means never arrived",
            mismatch_count, expected_means.size());
        if (mismatch_count == 0 && expected_means.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
